@@ rtl/tracked_point_reference_store_top_macros.svh @@
// Assertion macros shared by the checker of the tracked point reference store.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TRACKED_POINT_REFERENCE_STORE_TOP_MACROS_SVH
`define TRACKED_POINT_REFERENCE_STORE_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TPRS_CHECK_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define TPRS_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/tprs_pkg.sv @@
// Shared types and constants of the tracked point reference store.
// Used by the controller, the datapath, the top level and the checker.
package tprs_pkg;

  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_MEASURE = 2'd1;
  localparam logic [1:0] OP_BANK    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_REANCHOR_EN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZNCC_THR    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRACK_FRAC  = 2'd2;

  localparam logic signed [15:0] ZNCC_THR_RESET   = 16'sd29491;
  localparam logic [16:0]        TRACK_FRAC_RESET = 17'd45875;

  typedef struct packed {
    logic [1:0]          operation;
    logic [INDEX_W-1:0]  point_index;
    logic [15:0]         grid_index;
    logic signed [23:0]  pos_x;
    logic signed [23:0]  pos_y;
    logic signed [23:0]  disp_u;
    logic signed [23:0]  disp_v;
    logic                converged;
    logic signed [15:0]  zncc;
    logic                last_point;
  } in_item_t;

  typedef struct packed {
    logic [15:0]         out_grid_index;
    logic signed [23:0]  start_x;
    logic signed [23:0]  start_y;
    logic signed [31:0]  total_u;
    logic signed [31:0]  total_v;
    logic                point_valid;
    logic                point_lost;
    logic [COUNT_W-1:0]  valid_count;
    logic                reanchor;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic read;
    logic compute;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rem_ge;
    logic out_busy;
  } ctrl_status_t;

endpackage

@@ rtl/tprs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tprs_ctrl.sv @@
// Controller of the tracked point reference store: sequences one item through
// index reduction, table read, update and result hand-off. Uses tprs_pkg.
module tprs_ctrl
  import tprs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_REDUCE  = 2'd1;
  localparam logic [1:0] S_COMPUTE = 2'd2;
  localparam logic [1:0] S_FINISH  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        // Wrap the point index into the table one subtraction per cycle.
        if (status.rem_ge) begin
          cmd.step = 1'b1;
        end else begin
          cmd.read = 1'b1;
          state_next = S_COMPUTE;
        end
      end
      S_COMPUTE: begin
        cmd.compute = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/tprs_datapath.sv @@
// Datapath of the tracked point reference store: item register, point table,
// saturating arithmetic, frame counters, configuration and output register.
// Uses tprs_pkg and tprs_ram.
module tprs_datapath
  import tprs_pkg::*;
#(
  parameter int POINTS    = 1024,
  parameter int ACC_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  in_item_t               in_data,
  input  ctrl_cmd_t              cmd,
  output ctrl_status_t           status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int EW = 65 + 2 * ACC_WIDTH;
  localparam int SW = (ACC_WIDTH + 1 > 33) ? ACC_WIDTH + 1 : 33;
  localparam logic [16:0] POINTS_CMP = 17'(POINTS);
  localparam logic signed [SW-1:0] MAX32  = {{(SW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] MIN32  = {{(SW - 31){1'b1}}, {31{1'b0}}};
  localparam logic signed [SW-1:0] MAXACC = {{(SW - ACC_WIDTH + 1){1'b0}},
                                             {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] MINACC = {{(SW - ACC_WIDTH + 1){1'b1}},
                                             {(ACC_WIDTH - 1){1'b0}}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [31:0] r;
    if (v > MAX32) begin
      r = MAX32[31:0];
    end else if (v < MIN32) begin
      r = MIN32[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [SW-1:0] v);
    logic signed [ACC_WIDTH-1:0] r;
    if (v > MAXACC) begin
      r = MAXACC[ACC_WIDTH-1:0];
    end else if (v < MINACC) begin
      r = MINACC[ACC_WIDTH-1:0];
    end else begin
      r = v[ACC_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // Configuration registers.
  logic               reanchor_en;
  logic signed [15:0] zncc_thr;
  logic [16:0]        track_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      reanchor_en <= 1'b0;
      zncc_thr    <= ZNCC_THR_RESET;
      track_frac  <= TRACK_FRAC_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REANCHOR_EN: reanchor_en <= cfg_data[0];
        CFG_ZNCC_THR:    zncc_thr    <= cfg_data[15:0];
        CFG_TRACK_FRAC:  track_frac  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Item register and index reduction.
  in_item_t           item;
  logic [INDEX_W-1:0] rem;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
      rem  <= in_data.point_index;
    end else if (cmd.step) begin
      rem <= rem - POINTS_CMP[INDEX_W-1:0];
    end
  end

  assign status.rem_ge = ({{(17 - INDEX_W){1'b0}}, rem} >= POINTS_CMP);

  // Point table: {lost, banked v, banked u, start y, start x, grid}.
  logic [AW-1:0] addr;
  logic          wr_en;
  logic [EW-1:0] wr_entry;
  logic [EW-1:0] rd_entry;

  assign addr = AW'(rem);

  tprs_ram #(
    .WIDTH(EW),
    .DEPTH(POINTS)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(addr),
    .wdata(wr_entry),
    .re   (cmd.read),
    .raddr(addr),
    .rdata(rd_entry)
  );

  logic                        lost_rd;
  logic signed [ACC_WIDTH-1:0] bu_rd;
  logic signed [ACC_WIDTH-1:0] bv_rd;
  logic signed [23:0]          sx_rd;
  logic signed [23:0]          sy_rd;
  logic [15:0]                 grid_rd;

  assign lost_rd = rd_entry[EW-1];
  assign bv_rd   = rd_entry[EW-2 -: ACC_WIDTH];
  assign bu_rd   = rd_entry[EW-2-ACC_WIDTH -: ACC_WIDTH];
  assign sy_rd   = rd_entry[63:40];
  assign sx_rd   = rd_entry[39:16];
  assign grid_rd = rd_entry[15:0];

  logic signed [SW-1:0]        sum_u;
  logic signed [SW-1:0]        sum_v;
  logic                        lost_new;
  logic signed [ACC_WIDTH-1:0] bu_new;
  logic signed [ACC_WIDTH-1:0] bv_new;
  logic signed [23:0]          sx_new;
  logic signed [23:0]          sy_new;
  logic [15:0]                 grid_new;
  logic                        wr_req;
  logic                        meas_valid;
  out_item_t                   res_next;
  out_item_t                   res;

  assign sum_u = SW'(bu_rd) + SW'(item.disp_u);
  assign sum_v = SW'(bv_rd) + SW'(item.disp_v);

  always_comb begin
    lost_new   = lost_rd;
    bu_new     = bu_rd;
    bv_new     = bv_rd;
    sx_new     = sx_rd;
    sy_new     = sy_rd;
    grid_new   = grid_rd;
    wr_req     = 1'b0;
    meas_valid = 1'b0;
    res_next   = '0;
    case (item.operation)
      OP_START: begin
        grid_new = item.grid_index;
        sx_new   = item.pos_x;
        sy_new   = item.pos_y;
        bu_new   = '0;
        bv_new   = '0;
        lost_new = 1'b0;
        wr_req   = 1'b1;
      end
      OP_MEASURE: begin
        meas_valid = item.converged && !lost_rd;
        if (meas_valid) begin
          res_next.total_u = sat32(sum_u);
          res_next.total_v = sat32(sum_v);
        end
      end
      OP_BANK: begin
        // A lost point keeps its banked displacement untouched.
        if (!lost_rd) begin
          if (!item.converged) begin
            lost_new = 1'b1;
          end else begin
            bu_new = sat_acc(sum_u);
            bv_new = sat_acc(sum_v);
          end
        end
        wr_req = 1'b1;
        res_next.total_u = sat32(SW'(bu_new));
        res_next.total_v = sat32(SW'(bv_new));
      end
      default: begin
      end
    endcase
    if (item.operation == OP_START || item.operation == OP_MEASURE ||
        item.operation == OP_BANK) begin
      res_next.out_grid_index = grid_new;
      res_next.start_x        = sx_new;
      res_next.start_y        = sy_new;
      res_next.point_lost     = lost_new;
      res_next.point_valid    = meas_valid;
    end
  end

  assign wr_en    = cmd.compute && wr_req;
  assign wr_entry = {lost_new, bv_new, bu_new, sy_new, sx_new, grid_new};

  always_ff @(posedge clk) begin
    if (cmd.compute) begin
      res <= res_next;
    end
  end

  // Frame counters.
  logic [COUNT_W-1:0] placed_cnt;
  logic [COUNT_W-1:0] measured_cnt;
  logic [COUNT_W-1:0] tracking_cnt;
  logic [COUNT_W-1:0] composed_cnt;
  logic               frame_end;
  logic [27:0]        frac_prod;
  logic [27:0]        track_scaled;
  logic               decision;

  assign frame_end    = (item.operation == OP_MEASURE) && item.last_point;
  assign frac_prod    = 28'(track_frac) * 28'(placed_cnt);
  assign track_scaled = {1'b0, tracking_cnt, 16'd0};
  assign decision     = reanchor_en && (placed_cnt != '0) && (measured_cnt != '0) &&
                        (track_scaled < frac_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      placed_cnt   <= '0;
      measured_cnt <= '0;
      tracking_cnt <= '0;
      composed_cnt <= '0;
    end else if (cmd.compute && item.operation == OP_MEASURE) begin
      placed_cnt <= bump(placed_cnt);
      if (item.converged) begin
        measured_cnt <= bump(measured_cnt);
        if (item.zncc >= zncc_thr) begin
          tracking_cnt <= bump(tracking_cnt);
        end
      end
      if (meas_valid) begin
        composed_cnt <= bump(composed_cnt);
      end
    end else if (cmd.finish && frame_end) begin
      placed_cnt   <= '0;
      measured_cnt <= '0;
      tracking_cnt <= '0;
      composed_cnt <= '0;
    end
  end

  // Output register; a waiting result blocks only the final step of the next item.
  out_item_t out_word;

  always_comb begin
    out_word             = res;
    out_word.valid_count = composed_cnt;
    out_word.reanchor    = frame_end && decision;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= out_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_busy = out_valid && out_stall;

endmodule

@@ rtl/tracked_point_reference_store_top.sv @@
// Tracked point reference store: keeps start position, banked displacement and
// lost mark per point, and composes totals and frame statistics.
//
// Input channel (in_valid, in_stall, in_data): one item per transfer. The
// operation field selects start, measure or bank; point_index is wrapped into
// the table of POINTS entries.
// Output channel (out_valid, out_stall, out_data): exactly one result per item.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready
// is always high; writes are meant to happen while no item is in flight.
//
// Sequence: each item passes the controller states idle (capture), reduce,
// compute and finish; in_stall is high outside idle, so a new item is taken
// only once the previous one is done. With a smaller table, the index wrap
// adds one subtraction of POINTS per cycle while the remainder is POINTS or
// more. The point table is read in reduce and written back in compute.
// A stalled result holds in the output register while the next item proceeds
// up to its final step. Synchronous reset clears the controller and the frame
// counters, resets the configuration; the table is undefined until started.
module tracked_point_reference_store_top
  import tprs_pkg::*;
#(
  parameter int POINTS    = 1024,
  parameter int ACC_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  tprs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  tprs_datapath #(
    .POINTS   (POINTS),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule

@@ rtl/tprs_checker.sv @@
// Port-level checks for the tracked point reference store, bound to the top.
// Uses tprs_pkg and the assertion macros header.
`include "tracked_point_reference_store_top_macros.svh"

module tprs_checker
  import tprs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A result waiting on a stalled receiver keeps its contents.
  `TPRS_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // One item at a time: right after a transfer the input side is closed.
  `TPRS_CHECK_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // A fresh result only comes out of an item that was in flight.
  `TPRS_CHECK_NOW(a_result_from_item, $rose(out_valid), $past(in_stall))

  // A composed point is never reported as lost.
  `TPRS_CHECK_NOW(a_valid_not_lost, out_valid && out_data.point_valid,
                  !out_data.point_lost)

endmodule

bind tracked_point_reference_store_top tprs_checker u_checker (.*);
